FILE: sv/magic_crc16_frame_record_parser_defines.svh
// Assertion macros for the frame record parser checker.
`ifndef MAGIC_CRC16_FRAME_RECORD_PARSER_DEFINES_SVH
`define MAGIC_CRC16_FRAME_RECORD_PARSER_DEFINES_SVH

// Consequent checked at the same edge as the antecedent.
`define MCFRP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked at the edge after the antecedent.
`define MCFRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mcfrp_pkg.sv
package mcfrp_pkg;

    localparam int CHANNELS    = 14;
    localparam int REC_BYTES   = 10;
    localparam int REC_BITS    = REC_BYTES * 8;
    localparam int PAYLOAD_LEN = CHANNELS * REC_BYTES;
    localparam int ADDR_W      = $clog2(PAYLOAD_LEN);
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W       = $clog2(REC_BYTES + 1);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PAYLOAD_LEN - 1);
    localparam logic [CH_W-1:0]   LAST_CH   = CH_W'(CHANNELS - 1);
    localparam logic [CNT_W-1:0]  REC_CNT   = CNT_W'(REC_BYTES);
    localparam logic [CNT_W-1:0]  REC_LAST  = CNT_W'(REC_BYTES - 1);

    localparam logic [7:0]  HDR_FIRST = 8'hAA;
    localparam logic [7:0]  HDR_SECOND = 8'h55;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI
    } t_phase;

    typedef enum logic [1:0] {
        RD_IDLE,
        RD_FETCH,
        RD_SEND
    } t_rd_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr_port;

    typedef struct packed {
        logic valid;
        logic ok;
    } t_frame_cmd;

endpackage

FILE: sv/mcfrp_if.sv
interface mcfrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface mcfrp_rec_if;
    logic              valid;
    logic              ready;
    logic [3:0]        channel;
    logic signed [31:0] position_count;
    logic signed [31:0] velocity_raw;
    logic [7:0]        status_bits;
    logic [3:0]        illegal_count;
    logic [3:0]        reject_count;
    logic              frame_ok;
    logic              last_record;

    modport source (
        output valid, output channel, output position_count, output velocity_raw,
        output status_bits, output illegal_count, output reject_count,
        output frame_ok, output last_record, input ready
    );
    modport sink (
        input valid, input channel, input position_count, input velocity_raw,
        input status_bits, input illegal_count, input reject_count,
        input frame_ok, input last_record, output ready
    );
endinterface

FILE: sv/magic_crc16_frame_record_parser.sv
// Fixed-length frame deframer with CRC-16/CCITT-FALSE check.
// i_byte: received bytes, one per transfer. The block hunts for the header
// AA 55, stores the payload in a byte memory (one write, one read port), then
// takes the CRC (low byte first).
// o_rec: results. A good frame gives one record per channel in wire order,
// the last one flagged; a bad CRC gives one failure result (all fields zero,
// last_record set) and hunting resumes with the two CRC bytes as window.
// Each byte takes one cycle while i_byte.ready is high. After the CRC high
// byte, ready stays low until every result has been taken: each record
// fetches its 10 bytes through the one memory read port, then waits for the
// output handshake; a failure result is shown the cycle after the byte.
// A stalled o_rec holds its record and keeps i_byte.ready low.
// Reset (i_rst_n low, synchronous) returns to hunting with an empty window
// and drops any pending results; the payload memory is not cleared.
module magic_crc16_frame_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcfrp_byte_if.sink  i_byte,
    mcfrp_rec_if.source o_rec
);
    import mcfrp_pkg::*;

    t_wr_port   w_wr;
    t_frame_cmd w_cmd;
    logic       w_rd_busy;

    mcfrp_deframer u_deframer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_rd_busy (w_rd_busy),
        .o_wr      (w_wr),
        .o_cmd     (w_cmd)
    );

    mcfrp_record_reader u_reader (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_cmd   (w_cmd),
        .o_busy  (w_rd_busy),
        .o_rec   (o_rec)
    );

endmodule

FILE: sv/mcfrp_deframer.sv
module mcfrp_deframer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mcfrp_byte_if.sink            i_byte,
    input  logic                  i_rd_busy,
    output mcfrp_pkg::t_wr_port   o_wr,
    output mcfrp_pkg::t_frame_cmd o_cmd
);
    import mcfrp_pkg::*;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    t_phase            r_phase, n_phase;
    logic [7:0]        r_prev, n_prev;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_crc_lo, n_crc_lo;
    logic              w_xfer;
    logic [7:0]        w_b;

    assign i_byte.ready = !i_rd_busy;
    assign w_xfer = i_byte.valid && !i_rd_busy;
    assign w_b = i_byte.rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_prev   <= '0;
            r_pos    <= '0;
            r_crc    <= CRC_INIT;
            r_crc_lo <= '0;
        end else begin
            r_phase  <= n_phase;
            r_prev   <= n_prev;
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_prev   = r_prev;
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        o_wr     = '0;
        o_cmd    = '0;
        if (w_xfer) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (r_prev == HDR_FIRST && w_b == HDR_SECOND) begin
                        n_phase = PH_PAYLOAD;
                        n_pos   = '0;
                        n_crc   = CRC_INIT;
                    end
                    n_prev = w_b;
                end
                PH_PAYLOAD: begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_pos;
                    o_wr.data = w_b;
                    n_crc     = crc_feed(r_crc, w_b);
                    n_pos     = r_pos + 1'b1;
                    if (r_pos == LAST_ADDR) begin
                        n_phase = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: begin
                    n_crc_lo = w_b;
                    n_phase  = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    o_cmd.valid = 1'b1;
                    if ({w_b, r_crc_lo} == r_crc) begin
                        o_cmd.ok = 1'b1;
                        n_phase  = PH_HUNT;
                        n_prev   = '0;
                    end else begin
                        n_prev = w_b;
                        // header sitting in the CRC bytes restarts the payload
                        if (r_crc_lo == HDR_FIRST && w_b == HDR_SECOND) begin
                            n_phase = PH_PAYLOAD;
                            n_pos   = '0;
                            n_crc   = CRC_INIT;
                        end else begin
                            n_phase = PH_HUNT;
                        end
                    end
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

endmodule

FILE: sv/mcfrp_record_reader.sv
module mcfrp_record_reader (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mcfrp_pkg::t_wr_port   i_wr,
    input  mcfrp_pkg::t_frame_cmd i_cmd,
    output logic                  o_busy,
    mcfrp_rec_if.source           o_rec
);
    import mcfrp_pkg::*;

    logic [7:0]          r_mem [PAYLOAD_LEN];
    logic [7:0]          r_rd_data;
    logic [REC_BITS-1:0] r_asm;

    t_rd_state         r_state, n_state;
    logic [CH_W-1:0]   r_rec, n_rec;
    logic [CNT_W-1:0]  r_issue, n_issue;
    logic [CNT_W-1:0]  r_got, n_got;
    logic [ADDR_W-1:0] r_rd_addr, n_rd_addr;
    logic              r_ok, n_ok;
    logic              r_rd_vld;
    logic              w_rd_en;
    logic              w_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
        if (r_rd_vld) begin
            r_asm <= {r_rd_data, r_asm[REC_BITS-1:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= RD_IDLE;
            r_rec     <= '0;
            r_issue   <= '0;
            r_got     <= '0;
            r_rd_addr <= '0;
            r_ok      <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rec     <= n_rec;
            r_issue   <= n_issue;
            r_got     <= n_got;
            r_rd_addr <= n_rd_addr;
            r_ok      <= n_ok;
            r_rd_vld  <= w_rd_en;
        end
    end

    assign w_last = !r_ok || (r_rec == LAST_CH);

    always_comb begin
        n_state   = r_state;
        n_rec     = r_rec;
        n_issue   = r_issue;
        n_got     = r_got;
        n_rd_addr = r_rd_addr;
        n_ok      = r_ok;
        w_rd_en   = 1'b0;
        unique case (r_state)
            RD_IDLE: begin
                if (i_cmd.valid) begin
                    n_rec     = '0;
                    n_issue   = '0;
                    n_got     = '0;
                    n_rd_addr = '0;
                    n_ok      = i_cmd.ok;
                    n_state   = i_cmd.ok ? RD_FETCH : RD_SEND;
                end
            end
            RD_FETCH: begin
                if (r_issue != REC_CNT) begin
                    w_rd_en   = 1'b1;
                    n_rd_addr = r_rd_addr + 1'b1;
                    n_issue   = r_issue + 1'b1;
                end
                if (r_rd_vld) begin
                    n_got = r_got + 1'b1;
                    if (r_got == REC_LAST) begin
                        n_state = RD_SEND;
                    end
                end
            end
            RD_SEND: begin
                if (o_rec.ready) begin
                    if (w_last) begin
                        n_state = RD_IDLE;
                    end else begin
                        n_rec   = r_rec + 1'b1;
                        n_issue = '0;
                        n_got   = '0;
                        n_state = RD_FETCH;
                    end
                end
            end
            default: n_state = RD_IDLE;
        endcase
    end

    assign o_busy               = (r_state != RD_IDLE);
    assign o_rec.valid          = (r_state == RD_SEND);
    assign o_rec.channel        = r_ok ? 4'(r_rec) : 4'd0;
    assign o_rec.position_count = r_ok ? signed'(r_asm[31:0]) : 32'sd0;
    assign o_rec.velocity_raw   = r_ok ? signed'(r_asm[63:32]) : 32'sd0;
    assign o_rec.status_bits    = r_ok ? r_asm[71:64] : 8'd0;
    assign o_rec.illegal_count  = r_ok ? r_asm[79:76] : 4'd0;
    assign o_rec.reject_count   = r_ok ? r_asm[75:72] : 4'd0;
    assign o_rec.frame_ok       = r_ok;
    assign o_rec.last_record    = w_last;

endmodule

FILE: sv/mcfrp_checker.sv
`include "magic_crc16_frame_record_parser_defines.svh"

module mcfrp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_out_channel,
    input logic       i_out_frame_ok,
    input logic       i_out_last
);
    `MCFRP_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped")
    `MCFRP_ASSERT_SAME(a_no_in_while_out, i_out_valid, !i_in_ready, "input open with result")
    `MCFRP_ASSERT_SAME(a_fail_shape, i_out_valid && !i_out_frame_ok, i_out_last && i_out_channel == 4'd0, "bad failure result")
    `MCFRP_ASSERT_NEXT(a_mid_frame, i_out_valid && i_out_ready && !i_out_last, !i_out_valid && !i_in_ready, "record sequence broken")
endmodule

bind magic_crc16_frame_record_parser mcfrp_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_byte.ready),
    .i_out_valid    (o_rec.valid),
    .i_out_ready    (o_rec.ready),
    .i_out_channel  (o_rec.channel),
    .i_out_frame_ok (o_rec.frame_ok),
    .i_out_last     (o_rec.last_record)
);

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mcfrp_pkg::*;

    typedef enum int {EXP_MODEL, EXP_FAIL, EXP_ZERO_FRAME} t_exp_src;
    typedef enum int {SEQ_BYTE, SEQ_FRAME, SEQ_BODY} t_seq_kind;
    typedef enum int {PAT_ZERO, PAT_ONES, PAT_EXT, PAT_INC, PAT_TAIL_AA, PAT_RAND} t_pattern;
    typedef enum int {CRC_GOOD, CRC_FLIP, CRC_HDR} t_crc_mode;

    typedef struct {
        t_seq_kind  kind;
        logic [7:0] value;
        t_pattern   pat;
        t_crc_mode  crc;
        t_exp_src   src;
    } t_seq_row;

    typedef struct packed {
        logic [3:0]  channel;
        logic [31:0] position_count;
        logic [31:0] velocity_raw;
        logic [7:0]  status_bits;
        logic [3:0]  illegal_count;
        logic [3:0]  reject_count;
        logic        frame_ok;
        logic        last_record;
    } t_rec;

    localparam int N_DIRECTED   = 20;
    localparam int LIMIT_CYCLES = 12500000;

    // src is applied to the last byte of the row only
    t_seq_row directed_rows [N_DIRECTED] = '{
        '{SEQ_BYTE,  8'h55, PAT_ZERO,    CRC_GOOD, EXP_MODEL},
        '{SEQ_BYTE,  8'hAA, PAT_ZERO,    CRC_GOOD, EXP_MODEL},
        '{SEQ_BYTE,  8'h00, PAT_ZERO,    CRC_GOOD, EXP_MODEL},
        '{SEQ_BYTE,  8'h55, PAT_ZERO,    CRC_GOOD, EXP_MODEL},
        '{SEQ_FRAME, 8'h00, PAT_ZERO,    CRC_GOOD, EXP_ZERO_FRAME},
        '{SEQ_FRAME, 8'h00, PAT_ONES,    CRC_GOOD, EXP_MODEL},
        '{SEQ_FRAME, 8'h00, PAT_EXT,     CRC_GOOD, EXP_MODEL},
        '{SEQ_FRAME, 8'h00, PAT_INC,     CRC_FLIP, EXP_FAIL},
        '{SEQ_BYTE,  8'h00, PAT_ZERO,    CRC_GOOD, EXP_MODEL},
        '{SEQ_BYTE,  8'hAA, PAT_ZERO,    CRC_GOOD, EXP_MODEL},
        '{SEQ_BYTE,  8'hAA, PAT_ZERO,    CRC_GOOD, EXP_MODEL},
        '{SEQ_BYTE,  8'h55, PAT_ZERO,    CRC_GOOD, EXP_MODEL},
        '{SEQ_BODY,  8'h00, PAT_INC,     CRC_GOOD, EXP_MODEL},
        '{SEQ_FRAME, 8'h00, PAT_EXT,     CRC_HDR,  EXP_MODEL},
        '{SEQ_BODY,  8'h00, PAT_ONES,    CRC_GOOD, EXP_MODEL},
        '{SEQ_FRAME, 8'h00, PAT_TAIL_AA, CRC_GOOD, EXP_MODEL},
        '{SEQ_BYTE,  8'h55, PAT_ZERO,    CRC_GOOD, EXP_MODEL},
        '{SEQ_FRAME, 8'h00, PAT_ZERO,    CRC_FLIP, EXP_FAIL},
        '{SEQ_BYTE,  8'hFF, PAT_ZERO,    CRC_GOOD, EXP_MODEL},
        '{SEQ_FRAME, 8'h00, PAT_RAND,    CRC_GOOD, EXP_MODEL}
    };

    logic i_clk;
    logic i_rst_n;

    mcfrp_byte_if byte_bus ();
    mcfrp_rec_if  rec_bus ();

    magic_crc16_frame_record_parser u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_bus),
        .o_rec   (rec_bus)
    );

    int         send_idle_pct;
    int         recv_idle_pct;
    int         fail_count;
    t_exp_src   tx_src;
    logic [7:0] frame_bytes [PAYLOAD_LEN];

    // deframer state mirror
    t_phase      pr_phase;
    logic [7:0]  pr_window;
    int          pr_fill;
    logic [15:0] pr_crc;
    logic [7:0]  pr_crc_lo;
    logic [7:0]  pr_mem [PAYLOAD_LEN];
    t_rec        fresh_recs [$];
    t_rec        expected_recs [$];

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #(LIMIT_CYCLES * 8);
        $display("testbench NOT OK");
        $finish;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [7:0] extremes [4] = '{8'h00, 8'hFF, 8'h80, 8'h7F};
        case ($urandom_range(9))
            0: return extremes[$urandom_range(3)];
            1: return HDR_FIRST;
            2: return HDR_SECOND;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void decode_rx(input logic [7:0] b);
        logic [15:0] rx_crc;
        t_rec        r;
        int          base;
        fresh_recs.delete();
        case (pr_phase)
            PH_HUNT: begin
                if (pr_window == HDR_FIRST && b == HDR_SECOND) begin
                    pr_phase = PH_PAYLOAD;
                    pr_fill  = 0;
                    pr_crc   = CRC_INIT;
                end
                pr_window = b;
            end
            PH_PAYLOAD: begin
                pr_mem[pr_fill] = b;
                pr_crc = crc16_step(pr_crc, b);
                pr_fill++;
                if (pr_fill >= PAYLOAD_LEN) pr_phase = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                pr_crc_lo = b;
                pr_phase  = PH_CRC_HI;
            end
            default: begin
                rx_crc = {b, pr_crc_lo};
                if (rx_crc == pr_crc) begin
                    for (int ch = 0; ch < CHANNELS; ch++) begin
                        base = ch * REC_BYTES;
                        r.channel        = 4'(ch);
                        r.position_count = {pr_mem[base+3], pr_mem[base+2],
                                            pr_mem[base+1], pr_mem[base]};
                        r.velocity_raw   = {pr_mem[base+7], pr_mem[base+6],
                                            pr_mem[base+5], pr_mem[base+4]};
                        r.status_bits    = pr_mem[base+8];
                        r.illegal_count  = pr_mem[base+9][7:4];
                        r.reject_count   = pr_mem[base+9][3:0];
                        r.frame_ok       = 1'b1;
                        r.last_record    = (ch == CHANNELS - 1);
                        fresh_recs.push_back(r);
                    end
                    pr_phase  = PH_HUNT;
                    pr_window = 8'h00;
                end else begin
                    r = '0;
                    r.last_record = 1'b1;
                    fresh_recs.push_back(r);
                    // header sitting in the CRC bytes starts a new payload
                    if (pr_crc_lo == HDR_FIRST && b == HDR_SECOND) begin
                        pr_phase = PH_PAYLOAD;
                        pr_fill  = 0;
                        pr_crc   = CRC_INIT;
                    end else begin
                        pr_phase = PH_HUNT;
                    end
                    pr_window = b;
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rec got;
        t_rec want;
        if (i_rst_n) begin
            if (byte_bus.valid && byte_bus.ready) begin
                decode_rx(byte_bus.rx_byte);
                case (tx_src)
                    EXP_FAIL: begin
                        want = '0;
                        want.last_record = 1'b1;
                        expected_recs.push_back(want);
                    end
                    EXP_ZERO_FRAME: begin
                        for (int ch = 0; ch < CHANNELS; ch++) begin
                            want = '0;
                            want.channel     = 4'(ch);
                            want.frame_ok    = 1'b1;
                            want.last_record = (ch == CHANNELS - 1);
                            expected_recs.push_back(want);
                        end
                    end
                    default: begin
                        foreach (fresh_recs[i]) expected_recs.push_back(fresh_recs[i]);
                    end
                endcase
            end
            if (rec_bus.valid && rec_bus.ready) begin
                got.channel        = rec_bus.channel;
                got.position_count = rec_bus.position_count;
                got.velocity_raw   = rec_bus.velocity_raw;
                got.status_bits    = rec_bus.status_bits;
                got.illegal_count  = rec_bus.illegal_count;
                got.reject_count   = rec_bus.reject_count;
                got.frame_ok       = rec_bus.frame_ok;
                got.last_record    = rec_bus.last_record;
                if (expected_recs.size() == 0) begin
                    $error("unexpected record transfer, channel %0d", got.channel);
                    fail_count++;
                end else begin
                    want = expected_recs.pop_front();
                    check_field("channel", want.channel, got.channel);
                    check_field("position_count", $signed(want.position_count),
                                $signed(got.position_count));
                    check_field("velocity_raw", $signed(want.velocity_raw),
                                $signed(got.velocity_raw));
                    check_field("status_bits", want.status_bits, got.status_bits);
                    check_field("illegal_count", want.illegal_count, got.illegal_count);
                    check_field("reject_count", want.reject_count, got.reject_count);
                    check_field("frame_ok", want.frame_ok, got.frame_ok);
                    check_field("last_record", want.last_record, got.last_record);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        rec_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic push_byte(input logic [7:0] b, input t_exp_src src);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            byte_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        byte_bus.valid   <= 1'b1;
        byte_bus.rx_byte <= b;
        tx_src           <= src;
        do @(posedge i_clk); while (!byte_bus.ready);
    endtask

    task automatic fill_pattern(input t_pattern p);
        logic [15:0] crc;
        logic        odd;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            odd = 1'((i / REC_BYTES) % 2);
            case (p)
                PAT_ZERO: frame_bytes[i] = 8'h00;
                PAT_ONES: frame_bytes[i] = 8'hFF;
                PAT_EXT: begin
                    // alternate int32 min/max per record
                    case (i % REC_BYTES)
                        0, 1, 2: frame_bytes[i] = odd ? 8'hFF : 8'h00;
                        3:       frame_bytes[i] = odd ? 8'h7F : 8'h80;
                        4, 5, 6: frame_bytes[i] = odd ? 8'h00 : 8'hFF;
                        7:       frame_bytes[i] = odd ? 8'h80 : 8'h7F;
                        8:       frame_bytes[i] = odd ? 8'h00 : 8'hFF;
                        default: frame_bytes[i] = odd ? 8'h0F : 8'hF0;
                    endcase
                end
                PAT_RAND: frame_bytes[i] = rand_byte();
                default:  frame_bytes[i] = 8'(i);
            endcase
        end
        if (p == PAT_TAIL_AA) begin
            // pick the last byte so the CRC high byte equals the header first byte
            crc = CRC_INIT;
            for (int i = 0; i < PAYLOAD_LEN - 1; i++) crc = crc16_step(crc, frame_bytes[i]);
            for (int v = 0; v < 256; v++) begin
                if (crc16_step(crc, 8'(v)) >> 8 == HDR_FIRST) frame_bytes[PAYLOAD_LEN-1] = 8'(v);
            end
        end
    endtask

    task automatic send_frame(input bit with_header, input t_pattern p, input t_crc_mode cm,
                              input t_exp_src src);
        logic [15:0] crc;
        logic [7:0]  lo;
        logic [7:0]  hi;
        fill_pattern(p);
        crc = CRC_INIT;
        foreach (frame_bytes[i]) crc = crc16_step(crc, frame_bytes[i]);
        if (cm == CRC_FLIP) crc = ~crc;
        if (cm == CRC_HDR) begin
            lo = HDR_FIRST;
            hi = HDR_SECOND;
        end else begin
            {hi, lo} = crc;
        end
        if (with_header) begin
            push_byte(HDR_FIRST, EXP_MODEL);
            push_byte(HDR_SECOND, EXP_MODEL);
        end
        foreach (frame_bytes[i]) push_byte(frame_bytes[i], EXP_MODEL);
        push_byte(lo, EXP_MODEL);
        push_byte(hi, src);
    endtask

    initial begin
        int n_seq;
        int pick;
        i_rst_n          = 1'b0;
        byte_bus.valid   = 1'b0;
        byte_bus.rx_byte = 8'h00;
        rec_bus.ready    = 1'b0;
        tx_src           = EXP_MODEL;
        fail_count       = 0;
        pr_phase         = PH_HUNT;
        pr_window        = 8'h00;
        pr_fill          = 0;
        pr_crc           = CRC_INIT;
        pr_crc_lo        = 8'h00;
        send_idle_pct    = 22;
        recv_idle_pct    = 77;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                SEQ_BYTE:  push_byte(directed_rows[i].value, directed_rows[i].src);
                SEQ_FRAME: send_frame(1'b1, directed_rows[i].pat, directed_rows[i].crc,
                                      directed_rows[i].src);
                default:   send_frame(1'b0, directed_rows[i].pat, directed_rows[i].crc,
                                      directed_rows[i].src);
            endcase
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 77 : 0;
            recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 22 : 0;
            n_seq = 0;
            while (n_seq < 12) begin
                pick = $urandom_range(99);
                if (pick < 55) begin
                    send_frame(1'b1, PAT_RAND, CRC_GOOD, EXP_MODEL);
                    n_seq++;
                end else if (pick < 68) begin
                    send_frame(1'b1, PAT_RAND, CRC_FLIP, EXP_MODEL);
                    n_seq++;
                end else if (pick < 75) begin
                    send_frame(1'b1, PAT_RAND, CRC_HDR, EXP_MODEL);
                    send_frame(1'b0, PAT_RAND, CRC_GOOD, EXP_MODEL);
                    n_seq++;
                end else if (pick < 82) begin
                    // truncated frame: following bytes land in its payload
                    push_byte(HDR_FIRST, EXP_MODEL);
                    push_byte(HDR_SECOND, EXP_MODEL);
                    repeat ($urandom_range(1, PAYLOAD_LEN - 1)) push_byte(rand_byte(), EXP_MODEL);
                    n_seq++;
                end else begin
                    repeat ($urandom_range(1, 6)) push_byte(rand_byte(), EXP_MODEL);
                end
            end
        end
        byte_bus.valid <= 1'b0;

        while (expected_recs.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
